// ===== design/pairwise_radial_force_unit_defines.svh =====
// ---------------------------------------------------------------------------
// pairwise radial force unit: assertion macros
// Shared property wrappers clocked on clk.
// ---------------------------------------------------------------------------
`ifndef PAIRWISE_RADIAL_FORCE_UNIT_DEFINES_SVH
`define PAIRWISE_RADIAL_FORCE_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define PRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, also checked across reset
`define PRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/prf_pkg.sv =====
// ---------------------------------------------------------------------------
// prf_pkg
// Types and fixed widths shared by the pairwise radial force unit.
// ---------------------------------------------------------------------------
package prf_pkg;

  localparam int POS_W       = 24;
  localparam int DIFF_W      = 25;
  localparam int MAG_W       = 25;
  localparam int REACH_W     = 24;
  localparam int RSQ_W       = 48;
  localparam int SCALE_W     = 16;
  localparam int SUMSQ_W     = 50;
  localparam int FORCE_W     = 32;
  localparam int LEN_W       = 29;
  localparam int REM_W       = 32;
  localparam int DIV_W       = 30;
  localparam int QUO_W       = 17;
  localparam int SQ_STEPS    = 29;
  localparam int DIV_STEPS   = 17;
  localparam int PROD1_W     = 34;
  localparam int PROD2_W     = 50;
  localparam int ROUND_SHIFT = 24;
  localparam int ROUND_W     = PROD2_W - ROUND_SHIFT;

  typedef enum logic [1:0] {
    CMD_REPEL   = 2'd0,
    CMD_ATTRACT = 2'd1,
    CMD_CW      = 2'd2,
    CMD_CCW     = 2'd3
  } cmd_t;

  // classification carried alongside the arithmetic
  typedef struct packed {
    cmd_t                        cmd;
    logic                        hit;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       dmag;
    logic [REACH_W-1:0]          reach;
    logic [SCALE_W-1:0]          smag;
  } carry_t;

  typedef struct packed {
    carry_t               c;
    logic [SUMSQ_W-1:0]   sumsq;
  } item_t;

endpackage

// ===== design/pairwise_radial_force_unit.sv =====
// ---------------------------------------------------------------------------
// pairwise_radial_force_unit
// Force between two points within a radius, repel, attract or swirl.
// ---------------------------------------------------------------------------
// Takes one pair every cycle while in_ready is high and returns one result per
// pair, in order. The path is 3 front stages (difference, squares, range
// test), one queue slot, then 51 back stages, of which a 29-stage square
// root and 17-stage restoring dividers (pct and the three unit-vector lanes
// run side by side) make up most. The queue between front and back lets
// either side stall; the output is a register stage, and the front keeps
// taking new pairs while a finished result waits, until the queue is full.
`include "pairwise_radial_force_unit_defines.svh"

module pairwise_radial_force_unit
  import prf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic signed [POS_W-1:0]   self_x,
  input  logic signed [POS_W-1:0]   self_y,
  input  logic signed [POS_W-1:0]   self_z,
  input  logic signed [POS_W-1:0]   other_x,
  input  logic signed [POS_W-1:0]   other_y,
  input  logic signed [POS_W-1:0]   other_z,
  input  logic [REACH_W-1:0]        reach,
  input  logic signed [SCALE_W-1:0] force_scale,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [FORCE_W-1:0] self_fx,
  output logic signed [FORCE_W-1:0] self_fy,
  output logic signed [FORCE_W-1:0] self_fz,
  output logic signed [FORCE_W-1:0] partner_fx,
  output logic signed [FORCE_W-1:0] partner_fy,
  output logic signed [FORCE_W-1:0] partner_fz,
  output logic                      in_range
);

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // classify
  prf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .self_x      (self_x),
    .self_y      (self_y),
    .self_z      (self_z),
    .other_x     (other_x),
    .other_y     (other_y),
    .other_z     (other_z),
    .reach       (reach),
    .force_scale (force_scale),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_item    (f_item)
  );

  // decoupling queue
  prf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // compute forces
  prf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .self_fx    (self_fx),
    .self_fy    (self_fy),
    .self_fz    (self_fz),
    .partner_fx (partner_fx),
    .partner_fy (partner_fy),
    .partner_fz (partner_fz),
    .in_range   (in_range)
  );

  // checks
  `PRF_ASSERT_IMP(a_out_of_range_zero, out_valid && !in_range, (self_fx == '0) && (self_fy == '0) && (self_fz == '0) && (partner_fx == '0) && (partner_fy == '0) && (partner_fz == '0), "forces nonzero out of range")
  `PRF_ASSERT_IMP(a_equal_opposite, out_valid, ((self_fx + partner_fx) == '0) && ((self_fy + partner_fy) == '0) && ((self_fz + partner_fz) == '0), "forces not equal and opposite")
  `PRF_ASSERT_NXT(a_reset_empty, rst, !out_valid, "result visible after reset")

endmodule

// ===== design/prf_front.sv =====
// ---------------------------------------------------------------------------
// prf_front
// Differences, squared distance and range test, three stages.
// ---------------------------------------------------------------------------
module prf_front
  import prf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic signed [POS_W-1:0]   self_x,
  input  logic signed [POS_W-1:0]   self_y,
  input  logic signed [POS_W-1:0]   self_z,
  input  logic signed [POS_W-1:0]   other_x,
  input  logic signed [POS_W-1:0]   other_y,
  input  logic signed [POS_W-1:0]   other_z,
  input  logic [REACH_W-1:0]        reach,
  input  logic signed [SCALE_W-1:0] force_scale,
  output logic                      out_valid,
  input  logic                      out_ready,
  output item_t                     out_item
);

  logic                  en;
  logic [2:0][DIFF_W-1:0] diff;
  logic [2:0][MAG_W-1:0]  dmag;
  logic [SCALE_W-1:0]    smag;

  logic                  a_valid;
  cmd_t                  a_cmd;
  logic [2:0][MAG_W-1:0] a_dmag;
  logic [2:0]            a_dneg;
  logic [REACH_W-1:0]    a_reach;
  logic [SCALE_W-1:0]    a_smag;
  logic                  a_sneg;

  logic                  b_valid;
  carry_t                b_c;
  logic [2:0][SUMSQ_W-1:0] b_sq;
  logic [RSQ_W-1:0]      b_rsq;

  logic [SUMSQ_W-1:0]    sumsq;
  carry_t                c_next;
  logic                  c_valid;
  item_t                 c_item;

  assign en       = !c_valid || out_ready;
  assign in_ready = en;

  // sign-extended differences and their magnitudes
  always_comb begin
    diff[0] = {self_x[POS_W-1], self_x} - {other_x[POS_W-1], other_x};
    diff[1] = {self_y[POS_W-1], self_y} - {other_y[POS_W-1], other_y};
    diff[2] = {self_z[POS_W-1], self_z} - {other_z[POS_W-1], other_z};
    for (int i = 0; i < 3; i++) begin
      dmag[i] = diff[i][DIFF_W-1] ? (~diff[i] + 1'b1) : diff[i];
    end
    smag = force_scale[SCALE_W-1] ? (~force_scale + 1'b1) : force_scale;
  end

  // stage a: differences
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_cmd   <= cmd_t'(cmd);
      a_dmag  <= dmag;
      a_dneg  <= {diff[2][DIFF_W-1], diff[1][DIFF_W-1], diff[0][DIFF_W-1]};
      a_reach <= reach;
      a_smag  <= smag;
      a_sneg  <= force_scale[SCALE_W-1];
    end
  end

  // stage b: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_c.cmd   <= a_cmd;
      b_c.hit   <= 1'b0;
      b_c.neg   <= a_dneg ^ {3{a_sneg}};
      b_c.dmag  <= a_dmag;
      b_c.reach <= a_reach;
      b_c.smag  <= a_smag;
      for (int i = 0; i < 3; i++) begin
        b_sq[i] <= {{(SUMSQ_W-MAG_W){1'b0}}, a_dmag[i]} *
                   {{(SUMSQ_W-MAG_W){1'b0}}, a_dmag[i]};
      end
      b_rsq <= {{(RSQ_W-REACH_W){1'b0}}, a_reach} * {{(RSQ_W-REACH_W){1'b0}}, a_reach};
    end
  end

  // stage c: sum and range test
  assign sumsq = b_sq[0] + b_sq[1] + b_sq[2];

  always_comb begin
    c_next     = b_c;
    c_next.hit = (b_c.reach != '0) &&
                 (sumsq <= {{(SUMSQ_W-RSQ_W){1'b0}}, b_rsq});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_item.c     <= c_next;
      c_item.sumsq <= sumsq;
    end
  end

  assign out_valid = c_valid;
  assign out_item  = c_item;

endmodule

// ===== design/prf_queue.sv =====
// ---------------------------------------------------------------------------
// prf_queue
// Small register queue between the front and back pipelines.
// ---------------------------------------------------------------------------
module prf_queue
  import prf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== design/prf_back.sv =====
// ---------------------------------------------------------------------------
// prf_back
// Pipelined square root, four division lanes, scaling and mode mapping.
// ---------------------------------------------------------------------------
module prf_back
  import prf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  item_t                     in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [FORCE_W-1:0] self_fx,
  output logic signed [FORCE_W-1:0] self_fy,
  output logic signed [FORCE_W-1:0] self_fz,
  output logic signed [FORCE_W-1:0] partner_fx,
  output logic signed [FORCE_W-1:0] partner_fy,
  output logic signed [FORCE_W-1:0] partner_fz,
  output logic                      in_range
);

  logic en;

  // square root pipeline
  logic               sq_v    [SQ_STEPS+1];
  carry_t             sq_c    [SQ_STEPS+1];
  logic [SUMSQ_W-1:0] sq_s    [SQ_STEPS+1];
  logic [REM_W-1:0]   sq_rem  [SQ_STEPS+1];
  logic [LEN_W-1:0]   sq_root [SQ_STEPS+1];

  // division pipeline, lane 0 is pct, lanes 1..3 the unit vector
  logic                     dv_v   [DIV_STEPS+1];
  carry_t                   dv_c   [DIV_STEPS+1];
  logic                     dv_lz  [DIV_STEPS+1];
  logic [DIV_W-1:0]         dv_len [DIV_STEPS+1];
  logic [DIV_W-1:0]         dv_rad [DIV_STEPS+1];
  logic [3:0][DIV_W-1:0]    dv_rem [DIV_STEPS+1];
  logic [3:0][QUO_W-1:0]    dv_q   [DIV_STEPS+1];

  logic                     m1_v;
  carry_t                   m1_c;
  logic [2:0][PROD1_W-1:0]  m1_t;
  logic                     m2_v;
  carry_t                   m2_c;
  logic [2:0][PROD2_W-1:0]  m2_p;
  logic                     o_v;

  logic [2:0][QUO_W-1:0]    unit;
  logic [2:0][PROD2_W-1:0]  rnd;
  logic [2:0][FORCE_W-1:0]  f;
  logic [2:0][FORCE_W-1:0]  nf;
  logic [2:0][FORCE_W-1:0]  s_next;
  logic [2:0][FORCE_W-1:0]  p_next;

  assign en        = !o_v || out_ready;
  assign in_ready  = en;
  assign out_valid = o_v;

  // root stage 0: load from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= in_valid;
    end
    if (en) begin
      sq_c[0]    <= in_item.c;
      sq_s[0]    <= in_item.sumsq;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // one root bit per stage over the radicand sumsq * 256
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [SUMSQ_W+7:0] radicand;
    logic [1:0]         pair;
    logic [REM_W-1:0]   cur;
    logic [REM_W-1:0]   trial;
    logic               take;

    assign radicand = {sq_s[k], 8'b0};
    assign pair     = radicand[SUMSQ_W+7-2*k -: 2];
    assign cur      = {sq_rem[k][REM_W-3:0], pair};
    assign trial    = {{(REM_W-LEN_W-2){1'b0}}, sq_root[k], 2'b01};
    assign take     = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (en) begin
        sq_c[k+1]    <= sq_c[k];
        sq_s[k+1]    <= sq_s[k];
        sq_rem[k+1]  <= take ? (cur - trial) : cur;
        sq_root[k+1] <= {sq_root[k][LEN_W-2:0], take};
      end
    end
  end

  // division setup: pct numerator and unit vector numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQ_STEPS];
    end
    if (en) begin
      dv_c[0]      <= sq_c[SQ_STEPS];
      dv_lz[0]     <= (sq_root[SQ_STEPS] == '0);
      dv_len[0]    <= {{(DIV_W-LEN_W){1'b0}}, sq_root[SQ_STEPS]};
      dv_rad[0]    <= {{(DIV_W-REACH_W-4){1'b0}}, sq_c[SQ_STEPS].reach, 4'b0};
      dv_rem[0][0] <= {{(DIV_W-REACH_W-4){1'b0}}, sq_c[SQ_STEPS].reach, 4'b0} -
                      {{(DIV_W-LEN_W){1'b0}}, sq_root[SQ_STEPS]};
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i+1] <= {{(DIV_W-MAG_W-4){1'b0}}, sq_c[SQ_STEPS].dmag[i], 4'b0};
      end
      dv_q[0] <= '0;
    end
  end

  // one quotient bit per stage in each lane
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [3:0][DIV_W-1:0] cur;
    logic [3:0][DIV_W-1:0] dvs;
    logic [3:0]            take;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        cur[l]  = (j == 0) ? dv_rem[j][l] : {dv_rem[j][l][DIV_W-2:0], 1'b0};
        dvs[l]  = (l == 0) ? dv_rad[j] : dv_len[j];
        take[l] = (cur[l] >= dvs[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (en) begin
        dv_c[j+1]   <= dv_c[j];
        dv_lz[j+1]  <= dv_lz[j];
        dv_len[j+1] <= dv_len[j];
        dv_rad[j+1] <= dv_rad[j];
        for (int l = 0; l < 4; l++) begin
          dv_rem[j+1][l] <= take[l] ? (cur[l] - dvs[l]) : cur[l];
          dv_q[j+1][l]   <= {dv_q[j][l][QUO_W-2:0], take[l]};
        end
      end
    end
  end

  // unit vector is zero for coincident points
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit[i] = dv_lz[DIV_STEPS] ? '0 : dv_q[DIV_STEPS][i+1];
    end
  end

  // multiply by pct, then by the scale magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
    end else if (en) begin
      m1_v <= dv_v[DIV_STEPS];
      m2_v <= m1_v;
    end
    if (en) begin
      m1_c <= dv_c[DIV_STEPS];
      m2_c <= m1_c;
      for (int i = 0; i < 3; i++) begin
        m1_t[i] <= {{(PROD1_W-QUO_W){1'b0}}, unit[i]} *
                   {{(PROD1_W-QUO_W){1'b0}}, dv_q[DIV_STEPS][0]};
        m2_p[i] <= {{(PROD2_W-PROD1_W){1'b0}}, m1_t[i]} *
                   {{(PROD2_W-SCALE_W){1'b0}}, m1_c.smag};
      end
    end
  end

  // round half away from zero, apply sign, map mode
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = m2_p[i] + (PROD2_W'(1) << (ROUND_SHIFT-1));
      f[i]   = {{(FORCE_W-ROUND_W){1'b0}}, rnd[i][PROD2_W-1:ROUND_SHIFT]};
      if (m2_c.neg[i]) begin
        f[i] = ~f[i] + 1'b1;
      end
      nf[i] = ~f[i] + 1'b1;
    end
    s_next = '0;
    p_next = '0;
    if (m2_c.hit) begin
      case (m2_c.cmd)
        CMD_REPEL: begin
          s_next = f;
          p_next = nf;
        end
        CMD_ATTRACT: begin
          s_next = nf;
          p_next = f;
        end
        CMD_CW: begin
          s_next[0] = nf[1];
          s_next[1] = f[0];
          p_next[0] = f[1];
          p_next[1] = nf[0];
        end
        CMD_CCW: begin
          s_next[0] = f[1];
          s_next[1] = nf[0];
          p_next[0] = nf[1];
          p_next[1] = f[0];
        end
        default: begin
          s_next = '0;
          p_next = '0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en) begin
      o_v <= m2_v;
    end
    if (en) begin
      self_fx    <= s_next[0];
      self_fy    <= s_next[1];
      self_fz    <= s_next[2];
      partner_fx <= p_next[0];
      partner_fy <= p_next[1];
      partner_fz <= p_next[2];
      in_range   <= m2_c.hit;
    end
  end

endmodule

// ===== tb/pairwise_radial_force_unit_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pairwise radial force unit checker
// Watches the pair and force channels, computes the expected forces of each
// accepted pair and compares them, in order, with the returned beats.
// ---------------------------------------------------------------------------
module pairwise_radial_force_unit_checker
  import prf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic signed [POS_W-1:0]   self_x,
  input  logic signed [POS_W-1:0]   self_y,
  input  logic signed [POS_W-1:0]   self_z,
  input  logic signed [POS_W-1:0]   other_x,
  input  logic signed [POS_W-1:0]   other_y,
  input  logic signed [POS_W-1:0]   other_z,
  input  logic [REACH_W-1:0]        reach,
  input  logic signed [SCALE_W-1:0] force_scale,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [FORCE_W-1:0] self_fx,
  input  logic signed [FORCE_W-1:0] self_fy,
  input  logic signed [FORCE_W-1:0] self_fz,
  input  logic signed [FORCE_W-1:0] partner_fx,
  input  logic signed [FORCE_W-1:0] partner_fy,
  input  logic signed [FORCE_W-1:0] partner_fz,
  input  logic                      in_range,
  output int                        errors,
  output int                        pending
);

  typedef struct packed {
    logic signed [2:0][FORCE_W-1:0] s;
    logic signed [2:0][FORCE_W-1:0] p;
    logic                           hit;
  } forces_t;

  forces_t expected_forces[$];

  function automatic longint sat_force(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // integer square root by bit pairs
  function automatic longint unsigned root_of(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // one axis of the scaled unit vector, rounded to Q16.16
  function automatic longint axis_force(longint d, longint unsigned len, longint sc,
                                        longint unsigned pct);
    longint unsigned u, prod, r;
    longint unsigned dm, sm;
    if (len == 0) return 0;
    dm = d < 0 ? -d : d;
    sm = sc < 0 ? -sc : sc;
    u = (dm << 20) / len;
    prod = u * sm * pct;
    r = (prod + (64'd1 << 23)) >> 24;
    return sat_force(((d < 0) != (sc < 0)) ? -longint'(r) : longint'(r));
  endfunction

  function automatic forces_t pair_forces(cmd_t op, longint sx, longint sy, longint sz,
                                          longint ox, longint oy, longint oz,
                                          longint unsigned rch, longint sc);
    forces_t r;
    longint d[3], f[3], s[3], p[3];
    longint unsigned sumsq, len, rad, pct;
    d[0] = sx - ox; d[1] = sy - oy; d[2] = sz - oz;
    s = '{0, 0, 0};
    p = '{0, 0, 0};
    sumsq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    r.hit = rch != 0 && sumsq <= rch * rch;
    if (r.hit) begin
      len = root_of(sumsq << 8);
      rad = rch << 4;
      pct = ((rad - len) << 16) / rad;
      for (int i = 0; i < 3; i++) f[i] = axis_force(d[i], len, sc, pct);
      case (op)
        CMD_REPEL:   for (int i = 0; i < 3; i++) begin s[i] = f[i]; p[i] = -f[i]; end
        CMD_ATTRACT: for (int i = 0; i < 3; i++) begin s[i] = -f[i]; p[i] = f[i]; end
        CMD_CW: begin
          s[0] = -f[1]; s[1] = f[0]; p[0] = f[1]; p[1] = -f[0];
        end
        default: begin
          s[0] = f[1]; s[1] = -f[0]; p[0] = -f[1]; p[1] = f[0];
        end
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      r.s[i] = FORCE_W'(sat_force(s[i]));
      r.p[i] = FORCE_W'(sat_force(p[i]));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    forces_t w;
    if (!rst && in_valid && in_ready)
      expected_forces = {expected_forces, pair_forces(cmd_t'(cmd), self_x, self_y, self_z,
        other_x, other_y, other_z, reach, force_scale)};
    if (!rst && out_valid && out_ready) begin
      if (expected_forces.size() == 0) begin
        report_mismatch("beat with nothing pending", 1, 0);
      end else begin
        w = expected_forces.pop_front();
        if (self_fx != w.s[0]) report_mismatch("self_fx", self_fx, w.s[0]);
        if (self_fy != w.s[1]) report_mismatch("self_fy", self_fy, w.s[1]);
        if (self_fz != w.s[2]) report_mismatch("self_fz", self_fz, w.s[2]);
        if (partner_fx != w.p[0]) report_mismatch("partner_fx", partner_fx, w.p[0]);
        if (partner_fy != w.p[1]) report_mismatch("partner_fy", partner_fy, w.p[1]);
        if (partner_fz != w.p[2]) report_mismatch("partner_fz", partner_fz, w.p[2]);
        if (in_range != w.hit) report_mismatch("in_range", in_range, w.hit);
      end
    end
    pending = expected_forces.size();
  end

endmodule

// ===== tb/pairwise_radial_force_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pairwise radial force unit testbench
// Drives directed and random point pairs with random gaps and output stalls;
// the checker predicts and compares every force beat.
// ---------------------------------------------------------------------------
module pairwise_radial_force_unit_tb
  import prf_pkg::*;
();

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = '0;
  logic signed [POS_W-1:0] self_x = '0, self_y = '0, self_z = '0;
  logic signed [POS_W-1:0] other_x = '0, other_y = '0, other_z = '0;
  logic [REACH_W-1:0] reach = 24'd1;
  logic signed [SCALE_W-1:0] force_scale = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FORCE_W-1:0] self_fx, self_fy, self_fz;
  logic signed [FORCE_W-1:0] partner_fx, partner_fy, partner_fz;
  logic in_range;
  int errors, pending;
  bit calm = 1'b0;

  always #4 clk = ~clk;

  pairwise_radial_force_unit dut (.*);
  pairwise_radial_force_unit_checker chk (.*);

  // sink stalls, none during the calm stretch
  always @(posedge clk)
    out_ready <= calm || ($urandom_range(99) >= 23);

  task automatic send_pair(cmd_t op, logic [POS_W-1:0] sx, sy, sz, ox, oy, oz,
                           logic [REACH_W-1:0] rch, logic [SCALE_W-1:0] sc);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= op;
    self_x <= sx; self_y <= sy; self_z <= sz;
    other_x <= ox; other_y <= oy; other_z <= oz;
    reach <= rch; force_scale <= sc;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // a pair near each other, mostly within reach
  task automatic send_near();
    logic [POS_W-1:0] sx, sy, sz;
    int span;
    span = 1 << $urandom_range(20, 1);
    sx = POS_W'($urandom); sy = POS_W'($urandom); sz = POS_W'($urandom);
    send_pair(cmd_t'($urandom_range(3)), sx, sy, sz,
      POS_W'(sx + $urandom_range(span) - span / 2),
      POS_W'(sy + $urandom_range(span) - span / 2),
      POS_W'(sz + $urandom_range(span) - span / 2),
      REACH_W'($urandom_range(2 * span, 1)), SCALE_W'($urandom));
  endtask

  initial begin
    cmd_t op;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: each mode, extremes, coincident, edge of reach, out of range
    for (int m = 0; m < 4; m++) begin
      op = cmd_t'(m);
      send_pair(op, 24'sd256, 24'sd512, -24'sd256, '0, '0, '0, 24'd1024, 16'sd256);
      send_pair(op, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000,
                24'h800000, 24'hffffff, 16'h8000);
      send_pair(op, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 24'sd100, 24'sd100,
                24'd5, 16'h7fff);
    end
    send_pair(CMD_REPEL, 24'sd300, '0, '0, '0, '0, '0, 24'd300, 16'h7fff);
    send_pair(CMD_ATTRACT, 24'sd301, '0, '0, '0, '0, '0, 24'd300, 16'h7fff);
    send_pair(CMD_CW, '0, 24'sd3, 24'sd4, '0, '0, '0, 24'd5, 16'h8000);
    send_pair(CMD_CCW, 24'sd1, '0, '0, '0, '0, '0, 24'hffffff, 16'h7fff);
    send_pair(CMD_REPEL, 24'h800000, '0, '0, 24'h7fffff, '0, '0, 24'hffffff, 16'h7fff);
    send_pair(CMD_ATTRACT, '0, '0, 24'sd1, '0, '0, '0, 24'd1, 16'h0001);
    send_pair(CMD_CW, 24'sd5, '0, '0, '0, '0, '0, 24'd1, 16'h0000);
    // random: near pairs mostly, plus fully random noise
    for (int n = 0; n < 1000; n++) begin
      calm = (n >= 400 && n < 550);
      if ($urandom_range(9) < 8) send_near();
      else send_pair(cmd_t'($urandom_range(3)), POS_W'($urandom), POS_W'($urandom),
                     POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     POS_W'($urandom), REACH_W'($urandom_range(24'hffffff, 1)),
                     SCALE_W'($urandom));
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0)
      $display("pairwise_radial_force_unit verification clean");
    else
      $display("pairwise_radial_force_unit verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("pairwise_radial_force_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/prf_pkg.sv
design/prf_front.sv
design/prf_queue.sv
design/prf_back.sv
design/pairwise_radial_force_unit.sv
tb/pairwise_radial_force_unit_checker.sv
tb/pairwise_radial_force_unit_tb.sv
